FILE: hw/rtl/mtt_pkg.sv
// Shared types, character constants and the Morse code table of the translator.
// Used by every module of the block; depends on nothing else.
package mtt_pkg;

   localparam int MTT_TABLE_SIZE  = 29;
   localparam int MTT_MAX_SYMBOLS = 6;
   localparam int MTT_QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef enum logic {
      DIR_ENCODE = 1'b0,
      DIR_DECODE = 1'b1
   } direction_type;

   // Bit i of a code holds symbol i: 0 for a dot, 1 for a dash.
   typedef struct packed {
      logic [7:0] ch;
      logic [2:0] len;
      logic [5:0] bits;
   } code_entry_type;

   typedef struct packed {
      logic       found;
      logic [2:0] len;
      logic [5:0] bits;
   } enc_code_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] ch;
   } dec_char_type;

   // One classified request as handed from the front part to the back part.
   typedef struct packed {
      logic       is_dec;
      logic       sep;
      logic [5:0] bits;
      logic [7:0] ch0;
      logic [7:0] ch1;
      logic [2:0] count;
   } job_type;

   localparam code_entry_type CODE_TABLE [MTT_TABLE_SIZE] = '{
      '{8'h41, 3'd2, 6'b000010}, '{8'h42, 3'd4, 6'b000001},
      '{8'h43, 3'd4, 6'b000101}, '{8'h44, 3'd3, 6'b000001},
      '{8'h45, 3'd1, 6'b000000}, '{8'h46, 3'd4, 6'b000100},
      '{8'h47, 3'd3, 6'b000011}, '{8'h48, 3'd4, 6'b000000},
      '{8'h49, 3'd2, 6'b000000}, '{8'h4A, 3'd4, 6'b001110},
      '{8'h4B, 3'd3, 6'b000101}, '{8'h4C, 3'd4, 6'b000010},
      '{8'h4D, 3'd2, 6'b000011}, '{8'h4E, 3'd2, 6'b000001},
      '{8'h4F, 3'd3, 6'b000111}, '{8'h50, 3'd4, 6'b000110},
      '{8'h51, 3'd4, 6'b001011}, '{8'h52, 3'd3, 6'b000010},
      '{8'h53, 3'd3, 6'b000000}, '{8'h54, 3'd1, 6'b000001},
      '{8'h55, 3'd3, 6'b000100}, '{8'h56, 3'd4, 6'b001000},
      '{8'h57, 3'd3, 6'b000110}, '{8'h58, 3'd4, 6'b001001},
      '{8'h59, 3'd4, 6'b001101}, '{8'h5A, 3'd4, 6'b000011},
      '{8'h2E, 3'd6, 6'b101010}, '{8'h21, 3'd6, 6'b110101},
      '{8'h2D, 3'd6, 6'b100001}
   };

   function automatic enc_code_type enc_lookup(input logic [7:0] c);
      enc_code_type r;
      r = '0;
      for (int i = MTT_TABLE_SIZE - 1; i >= 0; i--) begin
         if (CODE_TABLE[i].ch == c) begin
            r.found = 1'b1;
            r.len   = CODE_TABLE[i].len;
            r.bits  = CODE_TABLE[i].bits;
         end
      end
      return r;
   endfunction

   // An empty piece gives a space; an invalid or unknown piece gives nothing.
   function automatic dec_char_type close_piece(input logic [5:0] bits,
                                                input logic [2:0] len,
                                                input logic       inv);
      dec_char_type r;
      r = '0;
      if (!inv && len == 3'd0) begin
         r.valid = 1'b1;
         r.ch    = CHAR_SPACE;
      end else if (!inv) begin
         for (int i = MTT_TABLE_SIZE - 1; i >= 0; i--) begin
            if (CODE_TABLE[i].len == len && CODE_TABLE[i].bits == bits) begin
               r.valid = 1'b1;
               r.ch    = CODE_TABLE[i].ch;
            end
         end
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/mtt_front.sv
// Front part of the translator: accepts requests, keeps the per-text state and
// classifies each request into a job for the back part. Depends on mtt_pkg.
module mtt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             direction,
   input  logic             accept,
   input  logic [7:0]       char_code,
   input  logic             first_of_text,
   input  logic             last_of_text,
   output mtt_pkg::job_type job,
   output logic             job_valid
);
   import mtt_pkg::*;

   logic       output_started_ff, output_started_in;
   logic [5:0] code_symbols_ff, code_symbols_in;
   logic [2:0] code_length_ff, code_length_in;
   logic       piece_invalid_ff, piece_invalid_in;

   logic         os;
   logic [5:0]   sym, sym_d;
   logic [2:0]   len, len_d;
   logic         inv, inv_d;
   logic [7:0]   upper;
   enc_code_type enc;
   dec_char_type r0, r1;
   logic [2:0]   enc_count;
   job_type      job_c;

   always_comb begin
      os  = first_of_text ? 1'b0 : output_started_ff;
      sym = first_of_text ? 6'd0 : code_symbols_ff;
      len = first_of_text ? 3'd0 : code_length_ff;
      inv = first_of_text ? 1'b0 : piece_invalid_ff;

      upper = (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_Z) ?
              char_code - CASE_OFFSET : char_code;
      enc = enc_lookup(upper);
      enc_count = {2'b00, os} + (enc.found ? enc.len : 3'd0);

      r0    = '0;
      sym_d = sym;
      len_d = len;
      inv_d = inv;
      if (char_code == CHAR_SPACE) begin
         r0    = close_piece(sym, len, inv);
         sym_d = 6'd0;
         len_d = 3'd0;
         inv_d = 1'b0;
      end else if (char_code == CHAR_DOT || char_code == CHAR_DASH) begin
         if (len >= 3'(MTT_MAX_SYMBOLS)) begin
            inv_d = 1'b1;
         end else begin
            if (char_code == CHAR_DASH) sym_d[len] = 1'b1;
            len_d = len + 3'd1;
         end
      end else begin
         inv_d = 1'b1;
      end
      r1 = '0;
      if (last_of_text) begin
         r1    = close_piece(sym_d, len_d, inv_d);
         sym_d = 6'd0;
         len_d = 3'd0;
         inv_d = 1'b0;
      end

      job_c        = '0;
      job_c.is_dec = (direction == DIR_DECODE);
      job_c.sep    = os;
      job_c.bits   = enc.bits;
      if (direction == DIR_ENCODE) begin
         job_c.count = enc_count;
      end else if (r0.valid && r1.valid) begin
         job_c.ch0   = r0.ch;
         job_c.ch1   = r1.ch;
         job_c.count = 3'd2;
      end else if (r0.valid) begin
         job_c.ch0   = r0.ch;
         job_c.count = 3'd1;
      end else if (r1.valid) begin
         job_c.ch0   = r1.ch;
         job_c.count = 3'd1;
      end

      output_started_in = output_started_ff;
      code_symbols_in   = code_symbols_ff;
      code_length_in    = code_length_ff;
      piece_invalid_in  = piece_invalid_ff;
      if (accept) begin
         if (direction == DIR_ENCODE) begin
            output_started_in = os | (enc_count != 3'd0);
            code_symbols_in   = sym;
            code_length_in    = len;
            piece_invalid_in  = inv;
         end else begin
            output_started_in = os;
            code_symbols_in   = sym_d;
            code_length_in    = len_d;
            piece_invalid_in  = inv_d;
         end
      end
   end

   assign job       = job_c;
   assign job_valid = accept && (job_c.count != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         output_started_ff <= 1'b0;
         code_symbols_ff   <= 6'd0;
         code_length_ff    <= 3'd0;
         piece_invalid_ff  <= 1'b0;
      end else begin
         output_started_ff <= output_started_in;
         code_symbols_ff   <= code_symbols_in;
         code_length_ff    <= code_length_in;
         piece_invalid_ff  <= piece_invalid_in;
      end
   end

endmodule

FILE: hw/rtl/mtt_queue.sv
// Short job queue between the front and back parts of the translator.
// Register-based FIFO of mtt_pkg::job_type entries; depends on mtt_pkg.
module mtt_queue #(
   parameter int DEPTH = mtt_pkg::MTT_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mtt_pkg::job_type push_data,
   input  logic             pop,
   output mtt_pkg::job_type pop_data,
   output logic             full,
   output logic             empty
);
   import mtt_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hw/rtl/mtt_back.sv
// Back part of the translator: takes jobs from the queue and sends their result
// characters one per cycle, while not stalled, via the output register. Depends on mtt_pkg.
module mtt_back (
   input  logic             clock,
   input  logic             reset,
   input  mtt_pkg::job_type q_job,
   input  logic             q_valid,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_last_of_run
);
   import mtt_pkg::*;

   logic       cur_valid_ff, cur_valid_in;
   job_type    cur_job_ff, cur_job_in;
   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_out_char_ff, rsp_out_char_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       out_free;
   logic       step;
   logic       step_last;
   logic [2:0] sym_idx;
   logic [7:0] ch;

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      step      = cur_valid_ff && out_free;
      step_last = (idx_ff == cur_job_ff.count - 3'd1);
      q_pop     = q_valid && (!cur_valid_ff || (step && step_last));

      sym_idx = idx_ff - {2'b00, cur_job_ff.sep};
      if (cur_job_ff.is_dec) begin
         ch = (idx_ff == 3'd0) ? cur_job_ff.ch0 : cur_job_ff.ch1;
      end else if (cur_job_ff.sep && idx_ff == 3'd0) begin
         ch = CHAR_SPACE;
      end else begin
         ch = cur_job_ff.bits[sym_idx] ? CHAR_DASH : CHAR_DOT;
      end

      cur_valid_in = cur_valid_ff;
      cur_job_in   = cur_job_ff;
      idx_in       = idx_ff;
      if (step) begin
         idx_in = idx_ff + 3'd1;
         if (step_last) cur_valid_in = 1'b0;
      end
      if (q_pop) begin
         cur_valid_in = 1'b1;
         cur_job_in   = q_job;
         idx_in       = 3'd0;
      end

      rsp_valid_in    = rsp_valid_ff;
      rsp_out_char_in = rsp_out_char_ff;
      rsp_last_in     = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in    = step;
         rsp_out_char_in = ch;
         rsp_last_in     = step_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = rsp_out_char_ff;
   assign rsp_last_of_run = rsp_last_ff;

   always_ff @(posedge clock) begin
      cur_job_ff      <= cur_job_in;
      idx_ff          <= idx_in;
      rsp_out_char_ff <= rsp_out_char_in;
      rsp_last_ff     <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/morse_text_translator.sv
// Top level of the Morse text translator: direction register, front part,
// job queue and back part. Depends on mtt_pkg, mtt_front, mtt_queue, mtt_back.
//
// Usage: text enters one byte per request on the req_ channel (valid/stall),
// with flags that mark the first and last byte of a text. Results leave one
// character per request on the rsp_ channel (valid/stall); rsp_last_of_run
// marks the final result caused by one request. A request may cause no result.
// The csr_ channel writes the direction bit (0 encodes, 1 decodes); csr_ready
// is always high, and the bit should only change while the block is idle.
// The first result of a request passes through the job queue, the current-job
// register of the back part and the output register. The back part sends one
// result per cycle while the receiver does not stall. A request gives one to
// seven results; encoding a six-symbol code with its separating space is the
// longest case. Requests that give no result are not queued. The job queue holds
// QUEUE_DEPTH classified requests, so the input keeps flowing while a result
// waits. When the receiver stalls, the output register holds its result and the
// queue fills; req_stall rises when it is full. Reset clears the direction to
// encoding, the text state and all pending results.
module morse_text_translator #(
   parameter int QUEUE_DEPTH = mtt_pkg::MTT_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_first_of_text,
   input  logic       req_last_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_run,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_direction
);
   import mtt_pkg::*;

   logic    direction_ff, direction_in;
   logic    req_accept;
   job_type front_job;
   logic    q_push;
   job_type q_job;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;

   assign csr_ready    = 1'b1;
   assign direction_in = (csr_valid && csr_ready) ? csr_direction : direction_ff;
   assign req_stall    = q_full;
   assign req_accept   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_ENCODE;
      end else begin
         direction_ff <= direction_in;
      end
   end

   mtt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .direction     (direction_ff),
      .accept        (req_accept),
      .char_code     (req_char_code),
      .first_of_text (req_first_of_text),
      .last_of_text  (req_last_of_text),
      .job           (front_job),
      .job_valid     (q_push)
   );

   mtt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_job),
      .pop       (q_pop),
      .pop_data  (q_job),
      .full      (q_full),
      .empty     (q_empty)
   );

   mtt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_job           (q_job),
      .q_valid         (!q_empty),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

   a_push_not_full : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job pushed into a full queue");

   a_pop_not_empty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("job popped from an empty queue");

   a_push_has_results : assert property (@(posedge clock) disable iff (reset)
      q_push |-> (front_job.count != 3'd0))
      else $error("queued job carries no result");

   a_reset_clears_output : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

endmodule
